// ===== design/fopp_pkg.sv =====
// Shared types and constants for the framed offset pair parser.
// No dependencies; imported by every design module except fopp_checker.
`default_nettype none

package fopp_pkg;

    localparam int unsigned PAYLOAD_LEN = 4;
    localparam int unsigned PCOUNT_W    = 3;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MIN  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MAX  = 8'd3;

    localparam logic [7:0]         HEADER_RESET = 8'd170;
    localparam logic [7:0]         TAIL_RESET   = 8'd85;
    localparam logic signed [15:0] MIN_RESET    = 16'sh8000;
    localparam logic signed [15:0] MAX_RESET    = 16'sh7FFF;

    typedef struct packed {
        logic [7:0]         header_byte;
        logic [7:0]         tail_byte;
        logic signed [15:0] offset_min;
        logic signed [15:0] offset_max;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
    } result_t;

endpackage

`default_nettype wire

// ===== design/fopp_cfg_regs.sv =====
// Configuration register file: header/tail bytes and the offset window.
// Depends on fopp_pkg.
`default_nettype none

module fopp_cfg_regs
    import fopp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte <= HEADER_RESET;
            cfg_reg.tail_byte   <= TAIL_RESET;
            cfg_reg.offset_min  <= MIN_RESET;
            cfg_reg.offset_max  <= MAX_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEADER_BYTE: cfg_reg.header_byte <= cfg_data[7:0];
                REG_TAIL_BYTE:   cfg_reg.tail_byte   <= cfg_data[7:0];
                REG_OFFSET_MIN:  cfg_reg.offset_min  <= cfg_data;
                REG_OFFSET_MAX:  cfg_reg.offset_max  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/fopp_frame_fsm.sv =====
// Frame parser state machine: header hunt, payload capture, tail and window check.
// Depends on fopp_pkg.
`default_nettype none

module fopp_frame_fsm
    import fopp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_en,
    input  wire logic [7:0] rx_byte,
    input  cfg_t            cfg,
    output result_t         result
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [PCOUNT_W-1:0]   count_reg, count_next;
    logic [7:0]            payload_reg [PAYLOAD_LEN];
    logic signed [15:0]    x_val, y_val;
    logic                  in_window;

    assign x_val = {payload_reg[0], payload_reg[1]};
    assign y_val = {payload_reg[2], payload_reg[3]};
    assign in_window = (x_val >= cfg.offset_min) && (x_val <= cfg.offset_max) &&
                       (y_val >= cfg.offset_min) && (y_val <= cfg.offset_max);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        result.valid    = 1'b0;
        result.offset_x = x_val;
        result.offset_y = y_val;
        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == cfg.header_byte) begin
                    phase_next = PH_DATA;
                    count_next = '0;
                end
            end
            PH_DATA: begin
                count_next = count_reg + PCOUNT_W'(1);
                if (count_next >= PCOUNT_W'(PAYLOAD_LEN)) begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL: begin
                result.valid = byte_en && (rx_byte == cfg.tail_byte) && in_window;
                phase_next   = PH_HUNT;
                count_next   = '0;
            end
            default: begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end else if (byte_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // payload store has no reset; every entry is written before the tail check
    always_ff @(posedge aclk) begin
        if (byte_en && phase_reg == PH_DATA) begin
            payload_reg[count_reg[1:0]] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== design/fopp_out_buf.sv =====
// Result register with a skid stage, so a byte can be taken while a result waits.
// Depends on fopp_pkg.
`default_nettype none

module fopp_out_buf
    import fopp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  result_t                  push,
    output logic                     space,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_offset_x,
    output logic signed [15:0]       m_offset_y
);

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = main_reg.valid && m_ready;
    assign space      = !skid_reg.valid;
    assign m_valid    = main_reg.valid;
    assign m_offset_x = main_reg.offset_x;
    assign m_offset_y = main_reg.offset_y;

    always_comb begin
        main_next = main_reg;
        skid_next = skid_reg;
        if (skid_reg.valid) begin
            // no push possible while the skid holds a request
            if (pop) begin
                main_next       = skid_reg;
                skid_next.valid = 1'b0;
            end
        end else if (push.valid) begin
            if (!main_reg.valid || pop) begin
                main_next = push;
            end else begin
                skid_next = push;
            end
        end else if (pop) begin
            main_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_reg.valid <= 1'b0;
            skid_reg.valid <= 1'b0;
        end else begin
            main_reg.valid <= main_next.valid;
            skid_reg.valid <= skid_next.valid;
        end
        main_reg.offset_x <= main_next.offset_x;
        main_reg.offset_y <= main_next.offset_y;
        skid_reg.offset_x <= skid_next.offset_x;
        skid_reg.offset_y <= skid_next.offset_y;
    end

endmodule

`default_nettype wire

// ===== design/framed_offset_pair_parser.sv =====
// Framed offset pair parser, top level. Takes one byte per cycle while s_ready is high.
// A result is registered into the result register, or into its skid stage while that is held, before m_valid shows it.
// s_ready drops only when both the result register and its skid stage are full.
// Synchronous active-low reset: header hunt, count zero, outputs empty, registers
// at their defaults (header 0xAA, tail 0x55, full signed 16-bit window).
`default_nettype none

module framed_offset_pair_parser
    import fopp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_rx_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [15:0]         m_offset_x,
    output logic signed [15:0]         m_offset_y,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t result;
    logic    space;
    logic    byte_en;

    assign s_ready = space;
    assign byte_en = s_valid && space;

    fopp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fopp_frame_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (s_rx_byte),
        .cfg     (cfg),
        .result  (result)
    );

    fopp_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (result),
        .space      (space),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_offset_x (m_offset_x),
        .m_offset_y (m_offset_y)
    );

endmodule

`default_nettype wire

// ===== design/fopp_checker.sv =====
// Port-level checks for framed_offset_pair_parser, bound to the top level.
// Watches the byte and result handshakes only; no package needed.
`default_nettype none

module fopp_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic signed [15:0]    m_offset_x,
    input wire logic signed [15:0]    m_offset_y
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("result pending after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_offset_x) && $stable(m_offset_y))
        else $error("stalled result changed");

    // back-pressure on bytes only while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no pending result");

    // a fresh result needs an accepted byte in the cycle before
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without an accepted byte");

endmodule

bind framed_offset_pair_parser fopp_checker u_fopp_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for framed_offset_pair_parser: byte requests in, offset pairs out.
// Needs fopp_pkg and the parser RTL; carries its own shadow parser to predict results.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fopp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_SHOWN   = 10;
    localparam int unsigned RAND_PHASES = 10;
    localparam int unsigned PHASE_BYTES = 100;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_TAIL = 2'd2
    } parse_phase_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } offset_pair_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [15:0]    m_offset_x;
    logic signed [15:0]    m_offset_y;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    framed_offset_pair_parser dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_offset_x (m_offset_x),
        .m_offset_y (m_offset_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // shadow copy of the parser and its registers
    logic [7:0]         shadow_header;
    logic [7:0]         shadow_tail;
    logic signed [15:0] shadow_min;
    logic signed [15:0] shadow_max;
    parse_phase_t       shadow_phase;
    logic [2:0]         shadow_count;
    logic [7:0]         shadow_payload [4];
    offset_pair_t       decoded_pair;

    offset_pair_t expected_offsets [$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Shadow parser: advances on every accepted byte request and register write.
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_header = HEADER_RESET;
            shadow_tail   = TAIL_RESET;
            shadow_min    = MIN_RESET;
            shadow_max    = MAX_RESET;
            shadow_phase  = PH_HUNT;
            shadow_count  = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEADER_BYTE: shadow_header = cfg_data[7:0];
                    REG_TAIL_BYTE:   shadow_tail   = cfg_data[7:0];
                    REG_OFFSET_MIN:  shadow_min    = cfg_data;
                    REG_OFFSET_MAX:  shadow_max    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (shadow_phase)
                    PH_HUNT: begin
                        if (s_rx_byte == shadow_header) begin
                            shadow_count = '0;
                            shadow_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        // a header value here is plain data
                        shadow_payload[shadow_count[1:0]] = s_rx_byte;
                        shadow_count = shadow_count + 3'd1;
                        if (shadow_count >= PAYLOAD_LEN)
                            shadow_phase = PH_TAIL;
                    end
                    PH_TAIL: begin
                        if (s_rx_byte == shadow_tail) begin
                            decoded_pair.x = {shadow_payload[0], shadow_payload[1]};
                            decoded_pair.y = {shadow_payload[2], shadow_payload[3]};
                            if (decoded_pair.x >= shadow_min && decoded_pair.x <= shadow_max &&
                                decoded_pair.y >= shadow_min && decoded_pair.y <= shadow_max)
                                expected_offsets.push_back(decoded_pair);
                        end
                        shadow_phase = PH_HUNT;
                        shadow_count = '0;
                    end
                    default: begin
                        shadow_phase = PH_HUNT;
                        shadow_count = '0;
                    end
                endcase
            end
        end
    end

    task automatic note_error(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge aclk) begin
        offset_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_offsets.size() == 0) begin
                note_error($sformatf("unexpected result x=%0d y=%0d", m_offset_x, m_offset_y));
            end else begin
                want = expected_offsets.pop_front();
                if (m_offset_x !== want.x)
                    note_error($sformatf("offset_x expected %0d got %0d", want.x, m_offset_x));
                if (m_offset_y !== want.y)
                    note_error($sformatf("offset_y expected %0d got %0d", want.y, m_offset_y));
            end
        end
    end

    // result side back-pressure: mostly short stalls, a few long ones, some long open runs
    initial begin
        int unsigned hold;
        int unsigned roll;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold != 0) begin
                hold--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    m_ready <= 1'b1;
                    hold = $urandom_range(0, 15);
                end else if (roll < 50) begin
                    m_ready <= 1'b1;
                    hold = $urandom_range(60, 150);
                end else if (roll < 90) begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(15, 40);
                end
            end
        end
    end

    function int unsigned pick_gap();
        int unsigned roll;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid is only dropped when a gap follows, so it never toggles within one step
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic [7:0] tl);
        send_byte(hdr);
        send_byte(x[15:8]);
        send_byte(x[7:0]);
        send_byte(y[15:8]);
        send_byte(y[7:0]);
        send_byte(tl);
    endtask

    // drain: the block is idle once every pending result is out and its pipe has emptied
    task automatic settle_link();
        s_valid <= 1'b0;
        repeat (4) @(posedge aclk);
        while (expected_offsets.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Upper data bits of the byte registers carry junk; the last write hits an unused index.
    task automatic apply_window(input logic [7:0] hdr, input logic [7:0] tl,
                                input logic signed [15:0] lo, input logic signed [15:0] hi);
        settle_link();
        write_reg(REG_HEADER_BYTE, {8'($urandom), hdr});
        write_reg(REG_TAIL_BYTE, {8'($urandom), tl});
        write_reg(REG_OFFSET_MIN, lo);
        write_reg(REG_OFFSET_MAX, hi);
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    endtask

    function automatic logic signed [15:0] edge_offset(input logic signed [15:0] lo,
                                                       input logic signed [15:0] hi);
        case ($urandom_range(0, 11))
            0:       return lo;
            1:       return lo - 16'sd1;
            2:       return lo + 16'sd1;
            3:       return hi;
            4:       return hi - 16'sd1;
            5:       return hi + 16'sd1;
            6:       return 16'sh8000;
            7:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_default_frame();
        send_frame(HEADER_RESET, 16'sh8000, 16'sh7FFF, TAIL_RESET);
    endtask

    task automatic test_header_in_payload();
        send_frame(HEADER_RESET, {HEADER_RESET, HEADER_RESET}, {HEADER_RESET, HEADER_RESET},
                   TAIL_RESET);
    endtask

    // a header value in the tail slot must not open a new frame
    task automatic test_bad_tail();
        send_frame(HEADER_RESET, 16'sh0102, 16'sh0304, HEADER_RESET);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h04);
        send_byte(TAIL_RESET);
    endtask

    task automatic test_window_edges();
        apply_window(HEADER_RESET, TAIL_RESET, -16'sd5, 16'sd5);
        send_frame(HEADER_RESET, 16'sd5, -16'sd5, TAIL_RESET);
    endtask

    task automatic test_random_traffic();
        logic [7:0]         hdr;
        logic [7:0]         tl;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] swap;
        int unsigned        sent;
        int unsigned        roll;
        int unsigned        cut;
        for (int phase_no = 0; phase_no < RAND_PHASES; phase_no++) begin
            hdr = 8'($urandom);
            tl  = 8'($urandom);
            lo  = 16'($urandom);
            hi  = 16'($urandom);
            case (phase_no)
                0: begin hdr = HEADER_RESET; tl = TAIL_RESET; lo = MIN_RESET; hi = MAX_RESET; end
                1: begin hdr = 8'h00; tl = 8'hFF; lo = 16'sh8000; hi = 16'sh7FFF; end
                2: begin hdr = 8'hFF; tl = 8'h00; lo = -16'sd100; hi = 16'sd100; end
                3: begin hdr = 8'h3C; tl = 8'h3C; lo = -16'sd1; hi = 16'sd0; end
                4: begin lo = 16'sh1234; hi = 16'sh1234; end
                5: begin lo = 16'sd100; hi = -16'sd100; end  // inverted: nothing passes
                6: begin lo = 16'sh8000; hi = -16'sd1; end
                7: begin lo = 16'sd0; hi = 16'sh7FFF; end
                8: ;
                default: begin
                    if (lo > hi) begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                end
            endcase
            apply_window(hdr, tl, lo, hi);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    send_frame(hdr, edge_offset(lo, hi), edge_offset(lo, hi), tl);
                    sent += 6;
                end else if (roll < 85) begin
                    send_byte(8'($urandom));
                    sent++;
                end else if (roll < 93) begin
                    send_frame(hdr, edge_offset(lo, hi), edge_offset(lo, hi),
                               tl ^ 8'($urandom_range(1, 255)));
                    sent += 6;
                end else begin
                    // short frame: whatever follows is taken as payload
                    cut = $urandom_range(0, 3);
                    send_byte(hdr);
                    repeat (cut) send_byte(8'($urandom));
                    sent += cut + 1;
                end
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_frame();
        test_header_in_payload();
        test_bad_tail();
        test_window_edges();
        test_random_traffic();

        settle_link();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
